FILE: sv/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// aescbc_pkg
// shared types, codes, tables and round functions of the aes-256 cbc engine
// ----------------------------------------------------------------------------
package aescbc_pkg;

  localparam int BlkBits = 128;
  localparam int CntW    = 5;
  localparam int CfgW    = 64;
  localparam int IdxW    = 3;
  localparam int RndW    = 4;
  localparam int NumRk   = 15;
  localparam int QDepth  = 2;

  localparam logic [CntW-1:0] FullCnt = 5'd16;

  localparam logic [IdxW-1:0] REG_KEY0 = 3'd0;
  localparam logic [IdxW-1:0] REG_KEY1 = 3'd1;
  localparam logic [IdxW-1:0] REG_KEY2 = 3'd2;
  localparam logic [IdxW-1:0] REG_KEY3 = 3'd3;
  localparam logic [IdxW-1:0] REG_IVH  = 3'd4;
  localparam logic [IdxW-1:0] REG_IVL  = 3'd5;
  localparam logic [IdxW-1:0] REG_MODE = 3'd6;

  localparam logic [1:0] KIND_REJ  = 2'd0;
  localparam logic [1:0] KIND_ENC  = 2'd1;
  localparam logic [1:0] KIND_ENC2 = 2'd2;
  localparam logic [1:0] KIND_DEC  = 2'd3;

  typedef struct packed {
    logic [BlkBits-1:0] blk;
    logic [1:0]         kind;
    logic               last;
  } q_entry_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [BlkBits-1:0] enc_round(input logic [BlkBits-1:0] s,
                                                   input logic [BlkBits-1:0] k,
                                                   input logic fin);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] x;
    logic [BlkBits-1:0] o;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = b[r + 4*((c+r) & 3)];
    for (int c = 0; c < 4; c++) begin
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ x ^ xt(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ x ^ xt(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ x ^ xt(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ x ^ xt(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = (fin ? t[i] : m[i]) ^ k[127-8*i -: 8];
    return o;
  endfunction

  function automatic logic [BlkBits-1:0] dec_round(input logic [BlkBits-1:0] s,
                                                   input logic [BlkBits-1:0] k,
                                                   input logic fin);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [7:0] m [16];
    logic [7:0] x2, x4, x8, y2, y4, y8, z2, z4, z8, w2, w4, w8;
    logic [7:0] e0, e1, e2, e3;
    logic [BlkBits-1:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r+4*c] = INV_SBOX[s[127-8*(r + 4*((c+4-r) & 3)) -: 8]];
    for (int i = 0; i < 16; i++) a[i] = t[i] ^ k[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      e0 = a[4*c]; e1 = a[4*c+1]; e2 = a[4*c+2]; e3 = a[4*c+3];
      x2 = xt(e0); x4 = xt(x2); x8 = xt(x4);
      y2 = xt(e1); y4 = xt(y2); y8 = xt(y4);
      z2 = xt(e2); z4 = xt(z2); z8 = xt(z4);
      w2 = xt(e3); w4 = xt(w2); w8 = xt(w4);
      // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
      m[4*c]   = (x8^x4^x2) ^ (y8^y2^e1) ^ (z8^z4^e2) ^ (w8^e3);
      m[4*c+1] = (x8^e0) ^ (y8^y4^y2) ^ (z8^z2^e2) ^ (w8^w4^e3);
      m[4*c+2] = (x8^x4^e0) ^ (y8^e1) ^ (z8^z4^z2) ^ (w8^w2^e3);
      m[4*c+3] = (x8^x2^e0) ^ (y8^y4^e1) ^ (z8^e2) ^ (w8^w4^w2);
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = fin ? a[i] : m[i];
    return o;
  endfunction

endpackage

FILE: sv/aescbc_front.sv
// ----------------------------------------------------------------------------
// aescbc_front
// classifies an input block and applies pkcs7 padding to short final blocks
// ----------------------------------------------------------------------------
module aescbc_front import aescbc_pkg::*; (
  input  logic [63:0]     data_high,
  input  logic [63:0]     data_low,
  input  logic [CntW-1:0] byte_count,
  input  logic            last_block,
  input  logic            decrypt,
  output q_entry_t        entry
);

  logic            rej;
  logic [7:0]      pad;
  logic [BlkBits-1:0] blk;

  always_comb begin
    rej = (byte_count > FullCnt) || (decrypt && byte_count != FullCnt) ||
          (!decrypt && !last_block && byte_count != FullCnt);
    pad = {3'd0, FullCnt - byte_count};
    blk = {data_high, data_low};
    if (!decrypt && last_block) begin
      for (int i = 0; i < 16; i++)
        if (i >= int'(byte_count)) blk[127-8*i -: 8] = pad;
    end
    entry.blk  = blk;
    entry.last = last_block;
    if (rej) begin
      entry.kind = KIND_REJ;
    end else if (decrypt) begin
      entry.kind = KIND_DEC;
    end else if (last_block && byte_count == FullCnt) begin
      entry.kind = KIND_ENC2;
    end else begin
      entry.kind = KIND_ENC;
    end
  end

endmodule

FILE: sv/aescbc_queue.sv
// ----------------------------------------------------------------------------
// aescbc_queue
// small fifo between the classifier and the cipher core
// ----------------------------------------------------------------------------
module aescbc_queue import aescbc_pkg::*; #(
  parameter int Depth = QDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output logic     rd_vld,
  output q_entry_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  q_entry_t            mem_r [Depth];
  logic [PtrW-1:0]     wp_r, rp_r;
  logic [PtrW:0]       cnt_r;

  assign full    = cnt_r == (PtrW+1)'(Depth);
  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

endmodule

FILE: sv/aescbc_back.sv
// ----------------------------------------------------------------------------
// aescbc_back
// key expansion, iterative aes-256 round unit, cbc chaining and unpadding
// ----------------------------------------------------------------------------
module aescbc_back import aescbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [255:0]       key,
  input  logic [BlkBits-1:0] iv,
  input  logic               key_wr,
  input  logic               q_vld,
  input  q_entry_t           q_data,
  output logic               q_pop,
  output logic               out_vld,
  input  logic               out_rdy,
  output logic [BlkBits-1:0] out_blk,
  output logic [CntW-1:0]    out_cnt,
  output logic               out_last,
  output logic               out_err
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEYX = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state_r;
  logic               kexp_r, msg_start_r;
  logic [31:0]        rkw_r [NumRk][4];
  logic [31:0]        kw_r [8];
  logic [5:0]         ki_r;
  logic [BlkBits-1:0] st_r, chain_r, ct_r;
  logic [RndW-1:0]    rnd_r;
  logic [1:0]         kind_r;
  logic               last_r, pad2_r;
  logic               ovld_r, olast_r, oerr_r;
  logic [BlkBits-1:0] oblk_r;
  logic [CntW-1:0]    ocnt_r;

  logic [BlkBits-1:0] rk, rk0, rk14, chain_use, dres;
  logic [31:0]        kt, kn;
  logic [7:0]         pad;
  logic               perr, can_out, enc_last;

  assign rk   = {rkw_r[rnd_r][0], rkw_r[rnd_r][1], rkw_r[rnd_r][2], rkw_r[rnd_r][3]};
  assign rk0  = {rkw_r[0][0], rkw_r[0][1], rkw_r[0][2], rkw_r[0][3]};
  assign rk14 = {rkw_r[NumRk-1][0], rkw_r[NumRk-1][1], rkw_r[NumRk-1][2], rkw_r[NumRk-1][3]};
  assign chain_use = msg_start_r ? iv : chain_r;
  assign q_pop   = state_r == ST_IDLE && q_vld && kexp_r;
  assign can_out = !ovld_r || out_rdy;
  assign enc_last = rnd_r == RndW'(NumRk-1);

  always_comb begin
    kt = kw_r[7];
    if (ki_r[2:0] == 3'd0) begin
      kt = sub_word({kw_r[7][23:0], kw_r[7][31:24]}) ^ {8'h01 << (ki_r[5:3] - 3'd1), 24'd0};
    end else if (ki_r[2:0] == 3'd4) begin
      kt = sub_word(kw_r[7]);
    end
    kn = kw_r[0] ^ kt;
  end

  always_comb begin
    dres = st_r ^ chain_r;
    pad  = dres[7:0];
    perr = (pad == 8'd0) || (pad > 8'd16);
    for (int i = 0; i < 16; i++)
      if (i < int'(pad) && dres[8*i +: 8] != pad) perr = 1'b1;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_vld && !kexp_r) begin
          rkw_r[0] <= '{key[255:224], key[223:192], key[191:160], key[159:128]};
          rkw_r[1] <= '{key[127:96], key[95:64], key[63:32], key[31:0]};
          kw_r <= '{key[255:224], key[223:192], key[191:160], key[159:128],
                    key[127:96], key[95:64], key[63:32], key[31:0]};
          ki_r <= 6'd8;
        end else if (q_pop) begin
          kind_r <= q_data.kind;
          last_r <= q_data.last;
          pad2_r <= q_data.kind == KIND_ENC2;
          chain_r <= chain_use;
          ct_r <= q_data.blk;
          if (q_data.kind == KIND_DEC) begin
            st_r  <= q_data.blk ^ rk14;
            rnd_r <= RndW'(NumRk-2);
          end else begin
            st_r  <= q_data.blk ^ chain_use ^ rk0;
            rnd_r <= RndW'(1);
          end
        end
      end
      ST_KEYX: begin
        rkw_r[ki_r[5:2]][ki_r[1:0]] <= kn;
        for (int i = 0; i < 7; i++) kw_r[i] <= kw_r[i+1];
        kw_r[7] <= kn;
        ki_r <= ki_r + 6'd1;
      end
      ST_RUN: begin
        if (kind_r == KIND_DEC) begin
          st_r <= dec_round(st_r, rk, rnd_r == '0);
          if (rnd_r != '0) rnd_r <= rnd_r - 1'b1;
        end else begin
          st_r <= enc_round(st_r, rk, enc_last);
          if (!enc_last) rnd_r <= rnd_r + 1'b1;
        end
      end
      ST_HOLD: begin
        if (can_out) begin
          if (kind_r == KIND_DEC) begin
            oblk_r  <= dres;
            chain_r <= ct_r;
            ocnt_r  <= (last_r && !perr) ? FullCnt - pad[CntW-1:0] : FullCnt;
            oerr_r  <= last_r && perr;
            olast_r <= last_r;
          end else if (kind_r != KIND_REJ) begin
            oblk_r  <= st_r;
            chain_r <= st_r;
            ocnt_r  <= FullCnt;
            oerr_r  <= 1'b0;
            olast_r <= last_r && !pad2_r;
            if (pad2_r) begin
              st_r   <= {16{8'h10}} ^ st_r ^ rk0;
              rnd_r  <= RndW'(1);
              pad2_r <= 1'b0;
            end
          end else begin
            oblk_r  <= '0;
            ocnt_r  <= '0;
            oerr_r  <= 1'b1;
            olast_r <= last_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kexp_r      <= 1'b0;
      msg_start_r <= 1'b1;
      ovld_r      <= 1'b0;
    end else begin
      if (state_r == ST_HOLD && can_out) begin
        ovld_r <= 1'b1;
      end else if (out_rdy) begin
        ovld_r <= 1'b0;
      end
      if (key_wr) begin
        kexp_r <= 1'b0;
      end else if (state_r == ST_KEYX && ki_r == 6'd59) begin
        kexp_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_vld && !kexp_r) begin
            state_r <= ST_KEYX;
          end else if (q_pop) begin
            msg_start_r <= q_data.last;
            state_r <= (q_data.kind == KIND_REJ) ? ST_HOLD : ST_RUN;
          end
        end
        ST_KEYX: begin
          if (ki_r == 6'd59) begin
            state_r <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if ((kind_r == KIND_DEC && rnd_r == '0) || (kind_r != KIND_DEC && enc_last))
            state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (can_out) begin
            state_r <= (kind_r != KIND_REJ && kind_r != KIND_DEC && pad2_r) ? ST_RUN : ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_vld  = ovld_r;
  assign out_blk  = oblk_r;
  assign out_cnt  = ocnt_r;
  assign out_last = olast_r;
  assign out_err  = oerr_r;

endmodule

FILE: sv/aes256_cbc_pkcs7_engine.sv
// ----------------------------------------------------------------------------
// aes256_cbc_pkcs7_engine
// aes-256 cbc engine with pkcs7 padding, one 16-byte block per transfer
// ----------------------------------------------------------------------------
// input stream: one block per transfer, tlast marks the final block of a
// message; output stream: one result per block, two for a full final
// encrypt block (the second carries the pad block), tlast on the final one.
// configuration: key words, iv and mode written through cfg_we/cfg_index/
// cfg_data; the user keeps to this while the engine is idle (not enforced).
// after a key write the first block waits for key expansion.
// each block then leaves the queue, makes fourteen passes through the
// single round unit and loads the output register.
// a two-entry queue takes new blocks while the core works.
// reset clears the queue, output valid flag and key-expanded flag and
// starts a new message with the iv.
// when the receiver stalls, the result waits in the output register and
// the core holds its next result until the register is free.
// ----------------------------------------------------------------------------
module aes256_cbc_pkcs7_engine import aescbc_pkg::*; #(
  parameter int QueueDepth = QDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [135:0]    in_tdata,   // data_high, data_low, byte_count, zero fill
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [135:0]    out_tdata,  // result_high, result_low, valid_bytes, zero fill
  output logic            out_tlast,
  output logic [0:0]      out_tuser,  // format_error
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic [CfgW-1:0]    key0_r, key1_r, key2_r, key3_r, ivh_r, ivl_r;
  logic               mode_r, q_full, q_vld, q_pop, key_wr, in_xfer;
  q_entry_t           f_entry, q_data;
  logic [BlkBits-1:0] o_blk;
  logic [CntW-1:0]    o_cnt;
  logic               o_err;

  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && !q_full;
  assign key_wr    = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      ivh_r  <= '0; ivl_r  <= '0; mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key0_r <= cfg_data;
        REG_KEY1: key1_r <= cfg_data;
        REG_KEY2: key2_r <= cfg_data;
        REG_KEY3: key3_r <= cfg_data;
        REG_IVH:  ivh_r  <= cfg_data;
        REG_IVL:  ivl_r  <= cfg_data;
        REG_MODE: mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aescbc_front u_front (
    .data_high  (in_tdata[63:0]),
    .data_low   (in_tdata[127:64]),
    .byte_count (in_tdata[132:128]),
    .last_block (in_tlast),
    .decrypt    (mode_r),
    .entry      (f_entry)
  );

  aescbc_queue #(.Depth(QueueDepth)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer),
    .wr_data (f_entry),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_vld  (q_vld),
    .rd_data (q_data)
  );

  aescbc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      ({key0_r, key1_r, key2_r, key3_r}),
    .iv       ({ivh_r, ivl_r}),
    .key_wr   (key_wr),
    .q_vld    (q_vld),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_blk  (o_blk),
    .out_cnt  (o_cnt),
    .out_last (out_tlast),
    .out_err  (o_err)
  );

  assign out_tdata = {3'd0, o_cnt, o_blk[63:0], o_blk[127:64]};
  assign out_tuser = o_err;

endmodule
